### hw/rtl/nws_pkg.sv
// Package for the weighted-sum neuron with sigmoid activation.
// Holds widths, saturation bounds and the sigmoid lookup table, which is built at elaboration.
// No dependencies.
package nws_pkg;

    localparam int DATA_WIDTH  = 16;
    localparam int PROD_WIDTH  = 2 * DATA_WIDTH;
    localparam int ACC_WIDTH   = 40;
    localparam int FRAC_BITS   = 12;
    localparam int SUM_WIDTH   = 20;
    localparam int ACT_WIDTH   = 16;
    localparam int CLAMP_WIDTH = 16;
    localparam int SIG_DEPTH   = 256;
    localparam int SIG_IDX_W   = $clog2(SIG_DEPTH);
    localparam int S_TDATA_W   = 2 * DATA_WIDTH;
    localparam int M_TDATA_W   = ((SUM_WIDTH + ACT_WIDTH + 7) / 8) * 8;

    localparam longint SUM_MAX = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    localparam longint ONE_Q24 = longint'(1) <<< 24;
    localparam longint ONE_Q32 = longint'(1) <<< 32;

    typedef logic [SIG_DEPTH-1:0][ACT_WIDTH-1:0] sig_table_t;

    // unsigned shift-and-subtract divide, only used while building the table
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        logic [63:0] q;
        logic [63:0] r;
        int          b;
        q = '0;
        r = '0;
        for (b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^-y in Q0.32, y in Q.24 with 0 <= y <= 1; truncated alternating Taylor series
    function automatic longint exp_neg_unit(input longint y);
        longint          sum;
        longint          term;
        longint          prod;
        longint unsigned mag;
        int              i;
        sum  = ONE_Q32;
        term = ONE_Q32;
        for (i = 1; i <= 24; i++) begin
            // quotient truncated toward zero
            prod = -(term * y);
            mag  = udiv((prod < 0) ? -prod : prod, longint'(i) * ONE_Q24);
            term = (prod < 0) ? -longint'(mag) : longint'(mag);
            sum  = sum + term;
        end
        if (sum < 0) begin
            sum = 0;
        end
        return sum;
    endfunction

    // e^-a in Q0.32, a in Q.24 with 0 <= a <= 8: (e^-1)^n * e^-f, rounded products
    function automatic longint unsigned exp_neg(input longint a);
        longint unsigned e1;
        longint unsigned e;
        longint unsigned ef;
        longint          n;
        longint          f;
        longint          i;
        e1 = longint'(exp_neg_unit(ONE_Q24));
        e  = ONE_Q32;
        n  = a >>> 24;
        f  = a & (ONE_Q24 - 1);
        for (i = 0; i < n; i++) begin
            e = (e * e1 + (longint'(1) <<< 31)) >> 32;
        end
        if (f != 0) begin
            ef = longint'(exp_neg_unit(f));
            e  = (e * ef + (longint'(1) <<< 31)) >> 32;
        end
        return e;
    endfunction

    // entry k samples the middle of bin k of [-8,8)
    function automatic sig_table_t build_sigmoid_table();
        sig_table_t      tbl;
        longint          k;
        longint          x;
        longint          a;
        longint unsigned e;
        longint unsigned den;
        longint unsigned num;
        longint unsigned s;
        tbl = '0;
        for (k = 0; k < SIG_DEPTH; k++) begin
            x   = -(8 * ONE_Q24) + (((2 * k + 1) <<< 27) / SIG_DEPTH);
            a   = (x < 0) ? -x : x;
            e   = exp_neg(a);
            den = ONE_Q32 + e;
            num = (x >= 0) ? (longint'(1) <<< 48) : (e << 16);
            s   = udiv(num + den / 2, den);
            if (s > 65535) begin
                s = 65535;
            end
            tbl[k] = ACT_WIDTH'(s);
        end
        return tbl;
    endfunction

    localparam sig_table_t SIGMOID_TABLE = build_sigmoid_table();

endpackage

### hw/rtl/nws_activation.sv
// Output stage logic: rounds the accumulated sum to Q8.12 with saturation
// and looks up its sigmoid. Depends on nws_pkg (widths, bounds, table).
module nws_activation
    import nws_pkg::*;
(
    input  logic signed [ACC_WIDTH-1:0] acc_i,
    output logic signed [SUM_WIDTH-1:0] weighted_sum_o,
    output logic        [ACT_WIDTH-1:0] activation_o
);

    localparam logic signed [ACC_WIDTH:0] RND_HALF =
        (ACC_WIDTH + 1)'(longint'(1) <<< (FRAC_BITS - 1));
    localparam logic signed [ACC_WIDTH:0] SUM_MAX_W = (ACC_WIDTH + 1)'(SUM_MAX);
    localparam logic signed [ACC_WIDTH:0] SUM_MIN_W = (ACC_WIDTH + 1)'(SUM_MIN);
    localparam logic signed [SUM_WIDTH-1:0] CLAMP_MAX =
        SUM_WIDTH'((longint'(1) <<< (CLAMP_WIDTH - 1)) - 1);
    localparam logic signed [SUM_WIDTH-1:0] CLAMP_MIN =
        SUM_WIDTH'(-(longint'(1) <<< (CLAMP_WIDTH - 1)));

    logic signed [ACC_WIDTH:0]     rnd_full;
    logic signed [ACC_WIDTH:0]     rounded;
    logic signed [SUM_WIDTH-1:0]   sum_sat;
    logic signed [CLAMP_WIDTH-1:0] clamped;
    logic        [CLAMP_WIDTH-1:0] biased;
    logic        [SIG_IDX_W-1:0]   tbl_idx;

    // round half up, then arithmetic shift down to Q8.12
    assign rnd_full = {acc_i[ACC_WIDTH-1], acc_i} + RND_HALF;
    assign rounded  = rnd_full >>> FRAC_BITS;

    always_comb begin
        priority if (rounded > SUM_MAX_W) begin
            sum_sat = SUM_WIDTH'(SUM_MAX_W);
        end else if (rounded < SUM_MIN_W) begin
            sum_sat = SUM_WIDTH'(SUM_MIN_W);
        end else begin
            sum_sat = rounded[SUM_WIDTH-1:0];
        end
    end

    // table covers [-8,8): clamp, offset to unsigned, top bits select the bin
    always_comb begin
        priority if (sum_sat > CLAMP_MAX) begin
            clamped = CLAMP_MAX[CLAMP_WIDTH-1:0];
        end else if (sum_sat < CLAMP_MIN) begin
            clamped = CLAMP_MIN[CLAMP_WIDTH-1:0];
        end else begin
            clamped = sum_sat[CLAMP_WIDTH-1:0];
        end
    end

    assign biased  = {~clamped[CLAMP_WIDTH-1], clamped[CLAMP_WIDTH-2:0]};
    assign tbl_idx = biased[CLAMP_WIDTH-1 -: SIG_IDX_W];

    assign weighted_sum_o = sum_sat;
    assign activation_o   = SIGMOID_TABLE[tbl_idx];

endmodule

### hw/rtl/neuron_weighted_sum_sigmoid.sv
// Top level of the weighted-sum neuron with sigmoid activation.
// Depends on nws_pkg and nws_activation.

// One (activation, weight) pair in signed Q4.12 is taken per transfer, one per clock
// when the output side keeps up. Each pair passes an input register, a product
// register (16x16 multiply) and a saturating 40-bit accumulate; a transfer with
// tlast set closes the neuron and, once it has passed the product, finished-sum
// and output registers, one result appears on the master side: the sum rounded
// half up and saturated to signed Q8.12, and its sigmoid in unsigned Q0.16 from
// a 256-entry table over [-8,8), saturating outside. Other transfers produce no
// result. The accumulator clears after each tlast. Each stage holds independently,
// so input continues to be taken while a result waits on the master side.
module neuron_weighted_sum_sigmoid
    import nws_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [15:0] upstream_value, [31:16] weight
    input  logic                 s_tlast,  // last_term
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // [19:0] weighted_sum, [35:20] activation, rest 0
);

    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH - 1){1'b0}}};

    // input stage
    logic                         in_valid_reg;
    logic signed [DATA_WIDTH-1:0] in_a_reg;
    logic signed [DATA_WIDTH-1:0] in_w_reg;
    logic                         in_last_reg;
    // product stage
    logic                         prod_valid_reg;
    logic signed [PROD_WIDTH-1:0] prod_reg;
    logic                         prod_last_reg;
    logic signed [PROD_WIDTH-1:0] prod_next;
    // accumulator and finished sum
    logic signed [ACC_WIDTH-1:0]  acc_reg;
    logic signed [ACC_WIDTH-1:0]  acc_next;
    logic signed [ACC_WIDTH:0]    acc_wide;
    logic signed [ACC_WIDTH-1:0]  acc_sat;
    logic                         fin_valid_reg;
    logic signed [ACC_WIDTH-1:0]  fin_acc_reg;
    // output register
    logic signed [SUM_WIDTH-1:0]  ws_reg;
    logic        [ACT_WIDTH-1:0]  act_reg;
    logic signed [SUM_WIDTH-1:0]  ws_next;
    logic        [ACT_WIDTH-1:0]  act_next;

    logic out_ready;
    logic fin_ready;
    logic prod_fire;
    logic prod_ready;
    logic in_ready;
    logic in_fire;

    assign out_ready  = !m_tvalid || m_tready;
    assign fin_ready  = !fin_valid_reg || out_ready;
    // non-final terms retire into the accumulator without waiting downstream
    assign prod_fire  = prod_valid_reg && (!prod_last_reg || fin_ready);
    assign prod_ready = !prod_valid_reg || prod_fire;
    assign in_ready   = !in_valid_reg || prod_ready;
    assign in_fire    = in_valid_reg && prod_ready;
    assign s_tready   = in_ready;

    assign prod_next = in_a_reg * in_w_reg;

    assign acc_wide = {acc_reg[ACC_WIDTH-1], acc_reg}
                    + (ACC_WIDTH + 1)'(prod_reg);

    always_comb begin
        priority if (acc_wide[ACC_WIDTH] != acc_wide[ACC_WIDTH-1]) begin
            acc_sat = acc_wide[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end else begin
            acc_sat = acc_wide[ACC_WIDTH-1:0];
        end
    end

    assign acc_next = prod_last_reg ? '0 : acc_sat;

    nws_activation u_act (
        .acc_i          (fin_acc_reg),
        .weighted_sum_o (ws_next),
        .activation_o   (act_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            fin_valid_reg  <= 1'b0;
            m_tvalid       <= 1'b0;
            acc_reg        <= '0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= s_tvalid;
            end
            if (prod_ready) begin
                prod_valid_reg <= in_valid_reg;
            end
            if (prod_fire) begin
                acc_reg <= acc_next;
            end
            if (fin_ready) begin
                fin_valid_reg <= prod_fire && prod_last_reg;
            end
            if (out_ready) begin
                m_tvalid <= fin_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            in_a_reg    <= s_tdata[DATA_WIDTH-1:0];
            in_w_reg    <= s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
            in_last_reg <= s_tlast;
        end
        if (in_fire) begin
            prod_reg      <= prod_next;
            prod_last_reg <= in_last_reg;
        end
        if (fin_ready) begin
            fin_acc_reg <= acc_sat;
        end
        if (out_ready && fin_valid_reg) begin
            ws_reg  <= ws_next;
            act_reg <= act_next;
        end
    end

    assign m_tdata = {{(M_TDATA_W - SUM_WIDTH - ACT_WIDTH){1'b0}}, act_reg, ws_reg};

endmodule

### bench/neuron_weighted_sum_sigmoid_test.sv
// Testbench for neuron_weighted_sum_sigmoid: directed term table, then random neurons.
// Expected results come from a local model, save typed-in sums; depends on nws_pkg and the RTL.
module neuron_weighted_sum_sigmoid_test;
    import nws_pkg::*;

    localparam longint Q24 = longint'(1) <<< 24;
    localparam longint Q32 = longint'(1) <<< 32;
    localparam longint ACC_HI = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint WSUM_HI = 524287;
    localparam longint WSUM_LO = -524288;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_TERMS = 450;

    typedef struct packed {
        logic [ACT_WIDTH-1:0] activation;
        logic [SUM_WIDTH-1:0] weighted_sum;
    } neuron_out_t;

    // known: weighted_sum is typed in; activation always comes from the local model
    typedef struct packed {
        logic signed [15:0] act_in;
        logic signed [15:0] wgt;
        bit                 is_last;
        int                 reps;
        bit                 known;
        int                 known_sum;
    } term_row_t;

    term_row_t directed_terms [25] = '{
        '{0, 0, 1, 1, 1, 0},                  // first neuron after reset
        '{1, 2048, 1, 1, 1, 1},               // exactly half an LSB rounds up
        '{1, 2047, 1, 1, 1, 0},
        '{-1, 2048, 1, 1, 1, 0},              // minus one half rounds up to zero
        '{-1, 2049, 1, 1, 1, -1},
        '{4096, 4096, 1, 1, 1, 4096},
        '{-4096, 4096, 1, 1, 1, -4096},
        '{-32768, -32768, 1, 1, 1, 262144},
        '{-32768, 32767, 1, 1, 1, -262136},
        '{32767, 32767, 1, 1, 1, 262128},
        '{32767, -32768, 0, 1, 0, 0},
        '{-32768, 32767, 0, 1, 0, 0},
        '{-32768, 32767, 1, 1, 1, -524288},   // sum saturates low
        '{-32768, -32768, 0, 1, 0, 0},
        '{-32768, -32768, 1, 1, 1, 524287},   // sum saturates high
        '{32767, 4096, 1, 1, 1, 32767},       // top of the sigmoid range
        '{32767, 4096, 0, 1, 0, 0},
        '{1, 4096, 1, 1, 1, 32768},           // just above it, clamped
        '{-32768, 4096, 1, 1, 1, -32768},     // bottom of the sigmoid range
        '{-32768, 4096, 0, 1, 0, 0},
        '{-1, 4096, 1, 1, 1, -32769},         // just below it, clamped
        '{2048, -3000, 0, 1, 0, 0},
        '{1234, 567, 1, 1, 0, 0},
        '{-32768, -32768, 1, 520, 1, 524287}, // accumulator pins at its top bound
        '{-32768, 32767, 1, 520, 1, -524288}  // and at its bottom bound
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [ACT_WIDTH-1:0] sigmoid_lut [SIG_DEPTH];
    longint               running_sum = 0;
    neuron_out_t          pending_outputs [$];
    int                   mismatches = 0;
    int                   cycle_count = 0;
    bit                   tx_gaps = 1'b1;
    bit                   rx_stalls = 1'b1;
    bit                   hold_off_request = 1'b0;

    neuron_weighted_sum_sigmoid dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [15:0] upstream_value, [31:16] weight
        .s_tlast  (s_tlast),    // last_term
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // [19:0] weighted_sum, [35:20] activation
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // e^-y in Q0.32 for y in Q.24 within [0,1]: series up to the y^24 term, each term truncated
    function automatic longint exp_frac_q32(input longint y);
        longint total;
        longint term;
        total = Q32;
        term  = Q32;
        for (int i = 1; i <= 24; i++) begin
            term  = -(term * y) / (longint'(i) * Q24);
            total = total + term;
        end
        return (total < 0) ? 0 : total;
    endfunction

    // e^-a in Q0.32 for a in Q.24 within [0,8], as (e^-1)^n * e^-f with rounded products
    function automatic longint unsigned exp_q32(input longint a);
        longint unsigned e;
        longint unsigned e1;
        longint unsigned ef;
        e1 = exp_frac_q32(Q24);
        e  = Q32;
        for (longint n = 0; n < (a >>> 24); n++) begin
            e = (e * e1 + 64'h8000_0000) >> 32;
        end
        if ((a & (Q24 - 1)) != 0) begin
            ef = exp_frac_q32(a & (Q24 - 1));
            e  = (e * ef + 64'h8000_0000) >> 32;
        end
        return e;
    endfunction

    // one multiply-accumulate; returns 1 with the neuron's outputs when the term closes it
    function automatic bit accumulate_term(input logic [15:0] act_in, input logic [15:0] wgt,
                                           input bit is_last, output neuron_out_t res);
        longint prod;
        longint wsum;
        longint clamped;
        longint idx;
        res  = '0;
        prod = longint'($signed(act_in)) * longint'($signed(wgt));
        if (prod > 0 && running_sum > ACC_HI - prod) begin
            running_sum = ACC_HI;
        end else if (prod < 0 && running_sum < ACC_LO - prod) begin
            running_sum = ACC_LO;
        end else begin
            running_sum = running_sum + prod;
        end
        if (!is_last) begin
            return 1'b0;
        end
        // Q16.24 -> Q8.12, round half up
        wsum = ((running_sum >>> (FRAC_BITS - 1)) + 1) >>> 1;
        if (wsum > WSUM_HI) wsum = WSUM_HI;
        if (wsum < WSUM_LO) wsum = WSUM_LO;
        clamped = wsum;
        if (clamped > 32767) clamped = 32767;
        if (clamped < -32768) clamped = -32768;
        idx = ((clamped + 32768) * SIG_DEPTH) >>> 16;
        if (idx >= SIG_DEPTH) idx = SIG_DEPTH - 1;
        res.weighted_sum = wsum[SUM_WIDTH-1:0];
        res.activation   = sigmoid_lut[idx];
        running_sum      = 0;
        return 1'b1;
    endfunction

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic logic [15:0] draw_value(input int style);
        if (style <= 4) begin
            return 16'($urandom_range(0, 16383)) - 16'd8192;   // within +/-2.0
        end else if (style <= 7) begin
            return 16'($urandom_range(0, 65535));
        end else begin
            case ($urandom_range(0, 4))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h0000;
                3:       return 16'h0001;
                default: return 16'hFFFF;
            endcase
        end
    endfunction

    task automatic offer_term(input logic [15:0] act_in, input logic [15:0] wgt,
                              input bit is_last, input bit known, input int known_sum);
        int          gap;
        neuron_out_t res;
        gap = tx_gaps ? sender_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {wgt, act_in};
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        if (accumulate_term(act_in, wgt, is_last, res)) begin
            if (known) begin
                res.weighted_sum = known_sum[SUM_WIDTH-1:0];
            end
            pending_outputs = {pending_outputs, res};
        end
    endtask

    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_outputs.size() != 0);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_request) begin
                hold_left        = 400;
                hold_off_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (rx_stalls && $urandom_range(0, 99) < 20) begin
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                          : $urandom_range(5, 29);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : output_check
        neuron_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outputs.size() == 0) begin
                mismatches++;
                $display("%0t unexpected result: weighted_sum %0d activation %0d", $time,
                         $signed(m_tdata[SUM_WIDTH-1:0]), m_tdata[SUM_WIDTH +: ACT_WIDTH]);
            end else begin
                want = pending_outputs.pop_front();
                if (m_tdata[SUM_WIDTH-1:0] !== want.weighted_sum) begin
                    mismatches++;
                    $display("%0t weighted_sum: expected %0d, got %0d", $time,
                             $signed(want.weighted_sum), $signed(m_tdata[SUM_WIDTH-1:0]));
                end
                if (m_tdata[SUM_WIDTH +: ACT_WIDTH] !== want.activation) begin
                    mismatches++;
                    $display("%0t activation: expected %0d, got %0d", $time,
                             want.activation, m_tdata[SUM_WIDTH +: ACT_WIDTH]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        longint          x;
        longint unsigned e;
        longint unsigned den;
        longint unsigned num;
        longint unsigned q;
        int              random_terms;
        int              neurons;
        int              len;
        int              style;

        // entry k samples the middle of bin k of [-8,8)
        for (int k = 0; k < SIG_DEPTH; k++) begin
            x   = -(8 * Q24) + (((2 * longint'(k) + 1) <<< 27) / SIG_DEPTH);
            e   = exp_q32((x < 0) ? -x : x);
            den = e + Q32;
            num = (x >= 0) ? (64'd1 << 48) : (e << 16);
            q   = (num + den / 2) / den;
            sigmoid_lut[k] = (q > 65535) ? 16'hFFFF : q[15:0];
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_terms[r]) begin
            for (int rep = 0; rep < directed_terms[r].reps; rep++) begin
                offer_term(directed_terms[r].act_in, directed_terms[r].wgt,
                           directed_terms[r].is_last && rep == directed_terms[r].reps - 1,
                           directed_terms[r].known, directed_terms[r].known_sum);
            end
        end
        drain_outputs();

        random_terms = 0;
        neurons      = 0;
        while (random_terms < RANDOM_TERMS) begin
            if ($urandom_range(0, 19) == 0) tx_gaps = $urandom_range(0, 1);
            if ($urandom_range(0, 19) == 0) rx_stalls = $urandom_range(0, 1);
            if (neurons == 2) begin
                // one-term neurons back to back while the output is held off
                hold_off_request = 1'b1;
                tx_gaps          = 1'b0;
                for (int i = 0; i < 40; i++) begin
                    offer_term(draw_value($urandom_range(0, 8)),
                               draw_value($urandom_range(0, 8)), 1'b1, 1'b0, 0);
                end
                random_terms += 40;
            end
            if (neurons == 5) begin
                drain_outputs();
            end
            len   = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            style = $urandom_range(0, 9);
            for (int i = 0; i < len; i++) begin
                if (style == 9) begin
                    offer_term(draw_value($urandom_range(0, 8)),
                               draw_value($urandom_range(0, 8)), i == len - 1, 1'b0, 0);
                end else begin
                    offer_term(draw_value(style), draw_value(style), i == len - 1, 1'b0, 0);
                end
            end
            random_terms += len;
            neurons++;
        end

        drain_outputs();
        repeat (16) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/nws_pkg.sv
hw/rtl/nws_activation.sv
hw/rtl/neuron_weighted_sum_sigmoid.sv
bench/neuron_weighted_sum_sigmoid_test.sv
